// ===== rtl/rpid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpid_pkg
// Types, codes and the fixed color palette of the run-length image decoder.
// ----------------------------------------------------------------------------
package rpid_pkg;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_REPEAT  = 2'd1,
		PH_LITERAL = 2'd2,
		PH_UNUSED  = 2'd3
	} phase_t;

	localparam logic [1:0] REG_PIXEL_TOTAL  = 2'd0;
	localparam logic [1:0] REG_PACKET_TOTAL = 2'd1;
	localparam logic [1:0] REG_RAW_MODE     = 2'd2;

	localparam int CFG_DATA_W = 24;

	typedef logic [23:0] rgb_t;

	localparam rgb_t PALETTE [256] = '{
		24'hFFFFFF, 24'hC6C7C6, 24'h210808, 24'h5A71A5, 24'hFFF800, 24'h00FF00, 24'h000000, 24'h808080,
		24'hA5A6A5, 24'hFFFFF7, 24'hFFCFFF, 24'hEFB6FF, 24'hFFAE63, 24'hCE9EFF, 24'hCEA6BD, 24'hFF9E00,
		24'hAD71FF, 24'hCE6194, 24'h9C61FF, 24'hBD7100, 24'h7349C6, 24'h73418C, 24'hFFCFFF, 24'h7B4900,
		24'h634131, 24'h4F307F, 24'h4A3063, 24'h5A3800, 24'h30303F, 24'h312042, 24'h4A3063, 24'h311821,
		24'h311800, 24'h211039, 24'h100818, 24'h4A8E4A, 24'hFFF7FF, 24'hFFFFCE, 24'hE7FFFF, 24'hEF70AF,
		24'hEFFFCE, 24'hF0E8F0, 24'hFFE7C6, 24'hFFE79C, 24'hC6EFF7, 24'hD0E0CF, 24'hD6D7DE, 24'hF7DF4A,
		24'hEFD77B, 24'hDED7BD, 24'hD6D79C, 24'h9FD8E0, 24'hD6C7C6, 24'hEFB694, 24'hD6A6C6, 24'hE7AE52,
		24'hDEAE7B, 24'hC6B69C, 24'h9CC7A5, 24'h90B0D0, 24'hEF8E8C, 24'hDEA608, 24'hEF866B, 24'h9CAE9C,
		24'h5ABEDE, 24'h9CAE5A, 24'hC68E8C, 24'hF77952, 24'hF77931, 24'hC6866B, 24'h9088B0, 24'h949684,
		24'h948E94, 24'h9C8E63, 24'hC67952, 24'h639E9C, 24'hC67139, 24'h94796B, 24'h8C7984, 24'h4296CE,
		24'h94794A, 24'h5F8090, 24'hA5695A, 24'h638663, 24'h9C6942, 24'hCE5131, 24'h846963, 24'h5A71A5,
		24'hC64942, 24'h637184, 24'h846939, 24'h607060, 24'hA54973, 24'h6B695A, 24'h5F685F, 24'h945152,
		24'h2996AD, 24'h6F6040, 24'h945129, 24'h406880, 24'h945910, 24'h2969AD, 24'h845142, 24'h406860,
		24'h52615A, 24'h7B5131, 24'hDE2029, 24'h635173, 24'h635142, 24'h40605F, 24'h6B5131, 24'hB53029,
		24'h5A5152, 24'hC62818, 24'h4F5050, 24'h425184, 24'h635121, 24'h4F5040, 24'h5A5131, 24'h425163,
		24'h7B4110, 24'h395152, 24'h634142, 24'h8C3029, 24'h4A4942, 24'h634129, 24'h526110, 24'h394942,
		24'h4A4929, 24'h424152, 24'h29495A, 24'h633829, 24'h10499C, 24'h4A4129, 24'h000000, 24'h40403F,
		24'h733008, 24'h314142, 24'hA52018, 24'h424110, 24'h394129, 24'h10417B, 24'h294129, 24'h632829,
		24'h10495A, 24'h423831, 24'h423821, 24'h5A3010, 24'h423042, 24'h294142, 24'h5A3000, 24'h18386B,
		24'h313839, 24'h393810, 24'h73BE63, 24'h423021, 24'h293829, 24'h183842, 24'h423008, 24'h18305A,
		24'h183829, 24'h293031, 24'h292842, 24'h293021, 24'h6B1008, 24'h422029, 24'h2F283F, 24'h422808,
		24'h293010, 24'h292829, 24'h183029, 24'h8496DE, 24'h521808, 24'h292818, 24'h212829, 24'h292808,
		24'h082842, 24'h312010, 24'h182829, 24'h000000, 24'h7B1010, 24'h102810, 24'h000000, 24'h212018,
		24'h004100, 24'h082829, 24'h311010, 24'hFF7900, 24'h08185A, 24'h181839, 24'h211808, 24'h311008,
		24'h5A0000, 24'h102018, 24'h000000, 24'h000000, 24'h102008, 24'h181021, 24'h0069FF, 24'h390800,
		24'h181810, 24'h001829, 24'h181800, 24'h001829, 24'h101810, 24'h210810, 24'h000000, 24'h001039,
		24'h000000, 24'h210808, 24'h181010, 24'hFF6100, 24'h001810, 24'h847131, 24'h006900, 24'h000000,
		24'h000000, 24'h210800, 24'hDE4129, 24'h101000, 24'h000000, 24'h210008, 24'h84BE8C, 24'hCE5110,
		24'h180800, 24'h001008, 24'h210000, 24'h000000, 24'h001000, 24'h00082F, 24'h100800, 24'h080810,
		24'h000000, 24'h080808, 24'h180000, 24'hFF4129, 24'h100008, 24'h000000, 24'h5A7942, 24'h9C9629,
		24'hBDC729, 24'hEFA631, 24'hADCF5A, 24'h009694, 24'hFF2818, 24'hA00050, 24'hA0C8F0, 24'hC6DFC6,
		24'hC6C7C6, 24'h00BEBD, 24'h000000, 24'h948E94, 24'h311821, 24'h00BE00, 24'hBD0000, 24'h000000
	};

endpackage
`default_nettype wire

// ===== rtl/rle_palette_image_decoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rle_palette_image_decoder_core
// Packed-bits run-length decoder with a fixed 256-color palette lookup.
// ----------------------------------------------------------------------------
// channel   signals                                      direction
// input     in_valid/in_ready, data_byte, frame_start    in
// output    out_valid/out_ready, pixel_index..frame_done out
// config    cfg_we, cfg_index, cfg_data                  in
//
// One byte per cycle while the input is not stalled: a byte is decoded in the
// cycle it transfers, and any result it yields lands in the output register on the same edge.
// The input is stalled only while a result waits in the output register and
// out_ready is low. Reset clears decode state and restores register defaults.
// ----------------------------------------------------------------------------
module rle_palette_image_decoder_core
	import rpid_pkg::*;
#(
	parameter int COUNT_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  frame_start,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 pixel_index,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue,
	output logic [7:0]                 run_length,
	output logic                       frame_done
);

	localparam int CW = COUNT_BITS;
	localparam int RW = (CW > 24) ? 24 : CW;

	logic [23:0]   pixel_total_q;
	logic [23:0]   packet_total_q;
	logic          raw_mode_q;
	phase_t        phase_q;
	logic [7:0]    literal_left_q;
	logic [7:0]    pending_run_q;
	logic [CW-1:0] pixels_q;
	logic [CW-1:0] packets_q;

	logic [CW-1:0] limit, plimit, pix_cur, pkt_cur, room, pix_nxt, pkt_nxt;
	phase_t        ph_cur, ph_nxt;
	logic [7:0]    lit_cur, lit_nxt, pend_cur, pend_nxt, run;
	logic          emit, take;

	// clamp to 2^CW-1: only matters when CW < 24
	always_comb begin
		if (CW < 24 && (pixel_total_q >> RW) != 24'd0) limit = '1;
		else limit = CW'(pixel_total_q[RW-1:0]);
		if (CW < 24 && (packet_total_q >> RW) != 24'd0) plimit = '1;
		else plimit = CW'(packet_total_q[RW-1:0]);
	end

	assign in_ready = !out_valid || out_ready;
	assign take = in_valid && in_ready;

	always_comb begin
		ph_cur   = frame_start ? PH_HEADER : phase_q;
		lit_cur  = frame_start ? 8'd0 : literal_left_q;
		pend_cur = frame_start ? 8'd0 : pending_run_q;
		pix_cur  = frame_start ? '0 : pixels_q;
		pkt_cur  = frame_start ? '0 : packets_q;
		room     = limit - pix_cur;
		ph_nxt   = ph_cur;
		lit_nxt  = lit_cur;
		pend_nxt = pend_cur;
		pkt_nxt  = pkt_cur;
		emit     = 1'b0;
		run      = 8'd1;
		if (pix_cur < limit) begin
			if (raw_mode_q) begin
				emit = 1'b1;
			end else begin
				case (ph_cur)
					PH_REPEAT: begin
						emit = 1'b1;
						run = (CW'(pend_cur) > room) ? room[7:0] : pend_cur;
						ph_nxt = PH_HEADER;
						pend_nxt = 8'd0;
					end
					PH_LITERAL: begin
						emit = 1'b1;
						if (lit_cur > 8'd1 ) lit_nxt = lit_cur - 8'd1;
						else begin
							lit_nxt = 8'd0;
							ph_nxt = PH_HEADER;
						end
					end
					default: begin
						if (pkt_cur < plimit) begin
							pkt_nxt = pkt_cur + 1'b1;
							if (data_byte[7]) begin
								pend_nxt = 8'd1 - data_byte;
								ph_nxt = PH_REPEAT;
							end else begin
								lit_nxt = data_byte + 8'd1;
								ph_nxt = PH_LITERAL;
							end
						end
					end
				endcase
			end
		end
		pix_nxt = emit ? pix_cur + CW'(run) : pix_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_total_q  <= 24'd1;
			packet_total_q <= 24'd0;
			raw_mode_q     <= 1'b0;
			phase_q        <= PH_HEADER;
			literal_left_q <= 8'd0;
			pending_run_q  <= 8'd0;
			pixels_q       <= '0;
			packets_q      <= '0;
			out_valid      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PIXEL_TOTAL:  pixel_total_q <= cfg_data;
					REG_PACKET_TOTAL: packet_total_q <= cfg_data;
					REG_RAW_MODE:     raw_mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (take) begin
				phase_q        <= ph_nxt;
				literal_left_q <= lit_nxt;
				pending_run_q  <= pend_nxt;
				pixels_q       <= pix_nxt;
				packets_q      <= pkt_nxt;
				out_valid      <= emit;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			pixel_index <= data_byte;
			red         <= PALETTE[data_byte][23:16];
			green       <= PALETTE[data_byte][15:8];
			blue        <= PALETTE[data_byte][7:0];
			run_length  <= run;
			frame_done  <= (pix_nxt == limit);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rpid_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpid_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rpid_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] run_length,
	input wire logic [7:0] pixel_index
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_index)
			&& $stable(run_length))
		else $error("result changed while stalled");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_length != 8'd0 && run_length <= 8'd129)
		else $error("run length out of range");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready) && !(out_valid && !out_ready) |=> !out_valid)
		else $error("result without transfer");

endmodule

bind rle_palette_image_decoder_core rpid_checker u_rpid_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .run_length(run_length),
	.pixel_index(pixel_index)
);
`default_nettype wire
